// File: rtl/core/mppq_pkg.sv
`default_nettype none
package mppq_pkg;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_NUM_SOURCES = 16;
   localparam int HANDLE_W = 16;
   localparam int LENGTH_W = 16;
   localparam int SOURCE_W = 4;
   localparam int POLICY_W = 3;
   localparam int ENTRY_W  = HANDLE_W + LENGTH_W + SOURCE_W;

   localparam logic [POLICY_W-1:0] POL_OLDEST   = 3'd0;
   localparam logic [POLICY_W-1:0] POL_NEWEST   = 3'd1;
   localparam logic [POLICY_W-1:0] POL_RROBIN   = 3'd2;
   localparam logic [POLICY_W-1:0] POL_SHORTEST = 3'd3;
   localparam logic [POLICY_W-1:0] POL_LONGEST  = 3'd4;
   localparam logic [POLICY_W-1:0] POL_FAIR     = 3'd5;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
      logic [SOURCE_W-1:0] source;
   } entry_type;
endpackage
`default_nettype wire

// File: rtl/core/multi_policy_packet_queue.sv
// sequence: a push goes straight to the result beat; a pull in fair mode runs
//   three scans over the entry memory (one read a cycle), the modulo as repeated
//   subtracts, then compaction
// throughput: one item at a time; next item taken once the result beat has left
// reset: synchronous, active high; count, round robin position, policy and
//   rotation memory (cleared by a sweep over its NUM_SOURCES entries after reset) start at zero
`default_nettype none
module multi_policy_packet_queue
   import mppq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_func,
   input  wire  [HANDLE_W-1:0]  req_pkt_handle,
   input  wire  [LENGTH_W-1:0]  req_byte_length,
   input  wire  [SOURCE_W-1:0]  req_source_id,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic                 rsp_valid_res,
   output logic [HANDLE_W-1:0]  rsp_out_handle,
   output logic [LENGTH_W-1:0]  rsp_out_length,
   output logic [SOURCE_W-1:0]  rsp_out_source,
   output logic                 rsp_dropped,
   output logic [4:0]           rsp_occupancy,
   input  wire                  csr_write,
   input  wire  [POLICY_W-1:0]  csr_wdata
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_FAIR_CNT, S_ROT_RD, S_MOD, S_FAIR_SEL,
      S_FETCH, S_SHIFT_RD, S_SHIFT_WR, S_RESP
   } state_type;

   // rotation slot of a source, a small constant table
   function automatic logic [SW-1:0] src_slot(input logic [SOURCE_W-1:0] src);
      logic [SW-1:0] slot;
      slot = '0;
      for (int i = 0; i < (1 << SOURCE_W); i++)
         if (src == SOURCE_W'(i)) slot = SW'(i % NUM_SOURCES);
      return slot;
   endfunction

   state_type           state_ff;
   logic [POLICY_W-1:0] policy_ff;
   logic [CW-1:0]       count_ff;
   logic [AW-1:0]       rr_ff;
   logic [CW-1:0]       idx_ff;     // address issued
   logic                rd_vld_ff;  // data of idx_ff-1 arrives this cycle
   logic [CW-1:0]       best_ff;
   entry_type           best_e_ff;
   logic [SOURCE_W-1:0] low_ff;
   logic [CW-1:0]       n_ff;
   logic [CW-1:0]       mod_ff;
   logic [CW-1:0]       seen_ff;
   logic [CW-1:0]       sel_ff;
   logic [SW-1:0]       clr_ff;
   logic                got_ff;

   entry_type           mem [QUEUE_DEPTH];
   entry_type           rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                we;
   logic [AW-1:0]       wa;
   entry_type           wd;

   logic [CW-1:0]       rot_mem [NUM_SOURCES];
   logic [CW-1:0]       rot_rd_ff;
   logic                rot_we;
   logic [SW-1:0]       rot_wa;
   logic [CW-1:0]       rot_wd;
   logic [SW-1:0]       low_idx;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid;
   assign low_idx   = src_slot(low_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (we) mem[wa] <= wd;
      rot_rd_ff <= rot_mem[low_idx];
      if (rot_we) rot_mem[rot_wa] <= rot_wd;
   end

   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      we = 1'b0; wa = count_ff[AW-1:0];
      wd = '{handle: req_pkt_handle, length: req_byte_length, source: req_source_id};
      rot_we = 1'b0; rot_wa = clr_ff; rot_wd = '0;
      unique case (state_ff)
         S_IDLE: begin
            we = req_valid && !req_stall && req_func == FUNC_PUSH
                 && count_ff < CW'(QUEUE_DEPTH);
         end
         // selected entry is read ahead so its data is there on the first shift cycle
         S_FETCH: rd_addr = sel_ff[AW-1:0];
         S_SHIFT_RD: rd_addr = AW'(idx_ff + CW'(1));
         S_SHIFT_WR: begin
            we = 1'b1; wa = AW'(idx_ff - CW'(1)); wd = rd_data_ff;
         end
         S_CLEAR: rot_we = 1'b1;
         S_FAIR_SEL: begin
            rot_we = (idx_ff == '0); rot_wa = low_idx; rot_wd = mod_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         policy_ff <= POL_OLDEST;
         count_ff  <= '0;
         rr_ff     <= '0;
         rsp_valid <= 1'b0;
         clr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_write) policy_ff <= csr_wdata;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         rd_vld_ff <= (state_ff == S_SCAN || state_ff == S_FAIR_CNT
                       || state_ff == S_FAIR_SEL) && idx_ff < count_ff;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + SW'(1);
               if (32'(clr_ff) == NUM_SOURCES - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid && !req_stall) begin
               rsp_valid_res  <= 1'b0;
               rsp_out_handle <= '0;
               rsp_out_length <= '0;
               rsp_out_source <= '0;
               rsp_dropped    <= (req_func == FUNC_PUSH) && (count_ff >= CW'(QUEUE_DEPTH));
               idx_ff  <= '0;
               got_ff  <= 1'b0;
               if (req_func == FUNC_PUSH) begin
                  if (count_ff < CW'(QUEUE_DEPTH)) count_ff <= count_ff + CW'(1);
                  state_ff <= S_RESP;
               end else if (count_ff == '0) begin
                  state_ff <= S_RESP;
               end else begin
                  priority case (policy_ff)
                     POL_OLDEST: begin sel_ff <= '0; state_ff <= S_FETCH; end
                     POL_NEWEST: begin
                        sel_ff <= count_ff - CW'(1); state_ff <= S_FETCH;
                     end
                     POL_RROBIN: begin
                        mod_ff <= CW'(rr_ff) + CW'(1); n_ff <= count_ff;
                        state_ff <= S_MOD;
                     end
                     POL_SHORTEST, POL_LONGEST, POL_FAIR: state_ff <= S_SCAN;
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            // min/max length or minimum source over the entries
            S_SCAN: begin
               if (idx_ff < count_ff) idx_ff <= idx_ff + CW'(1);
               if (rd_vld_ff) begin
                  if (idx_ff == CW'(1)) begin
                     best_ff <= '0; best_e_ff <= rd_data_ff; low_ff <= rd_data_ff.source;
                  end else begin
                     if ((policy_ff == POL_SHORTEST && rd_data_ff.length < best_e_ff.length)
                         || (policy_ff == POL_LONGEST
                             && rd_data_ff.length > best_e_ff.length)) begin
                        best_ff <= idx_ff - CW'(1); best_e_ff <= rd_data_ff;
                     end
                     if (rd_data_ff.source < low_ff) low_ff <= rd_data_ff.source;
                  end
               end
               if (idx_ff == count_ff && (rd_vld_ff || count_ff == '0)) begin
                  idx_ff <= '0; n_ff <= '0;
                  if (policy_ff == POL_FAIR) state_ff <= S_FAIR_CNT;
                  else begin
                     state_ff <= S_FETCH;
                     if (idx_ff == CW'(1)) sel_ff <= '0;
                     else if (rd_vld_ff
                              && ((policy_ff == POL_SHORTEST
                                   && rd_data_ff.length < best_e_ff.length)
                                  || (policy_ff == POL_LONGEST
                                      && rd_data_ff.length > best_e_ff.length)))
                        sel_ff <= idx_ff - CW'(1);
                     else sel_ff <= best_ff;
                  end
               end
            end
            S_FAIR_CNT: begin
               if (idx_ff < count_ff) idx_ff <= idx_ff + CW'(1);
               if (rd_vld_ff && rd_data_ff.source == low_ff) n_ff <= n_ff + CW'(1);
               if (idx_ff == count_ff && rd_vld_ff) state_ff <= S_ROT_RD;
            end
            S_ROT_RD: state_ff <= S_MOD;
            S_MOD: begin
               // (rotation+1) mod n by subtraction on first entry from round robin/fair
               if (policy_ff == POL_FAIR && idx_ff != '0) begin
                  mod_ff <= rot_rd_ff + CW'(1); idx_ff <= '0;
               end else if (mod_ff >= n_ff) mod_ff <= mod_ff - n_ff;
               else if (policy_ff == POL_RROBIN) begin
                  rr_ff <= mod_ff[AW-1:0]; sel_ff <= mod_ff; state_ff <= S_FETCH;
               end else begin
                  idx_ff <= '0; seen_ff <= '0; state_ff <= S_FAIR_SEL;
               end
            end
            // find the mod_ff-th entry of the lowest source
            S_FAIR_SEL: begin
               if (idx_ff < count_ff) idx_ff <= idx_ff + CW'(1);
               if (rd_vld_ff && rd_data_ff.source == low_ff && !got_ff) begin
                  if (seen_ff == mod_ff) begin
                     sel_ff <= idx_ff - CW'(1); got_ff <= 1'b1;
                  end
                  seen_ff <= seen_ff + CW'(1);
               end
               if (idx_ff == count_ff && rd_vld_ff) state_ff <= S_FETCH;
            end
            S_FETCH: begin
               idx_ff <= sel_ff; state_ff <= S_SHIFT_RD;
               got_ff <= 1'b0;
            end
            S_SHIFT_RD: begin
               if (!got_ff) begin
                  got_ff <= 1'b1;
                  rsp_valid_res  <= 1'b1;
                  rsp_out_handle <= rd_data_ff.handle;
                  rsp_out_length <= rd_data_ff.length;
                  rsp_out_source <= rd_data_ff.source;
               end
               if (idx_ff + CW'(1) < count_ff) begin
                  idx_ff <= idx_ff + CW'(1); state_ff <= S_SHIFT_WR;
               end else begin
                  count_ff <= count_ff - CW'(1); state_ff <= S_RESP;
               end
            end
            S_SHIFT_WR: state_ff <= S_SHIFT_RD;
            S_RESP: begin
               rsp_valid <= 1'b1; rsp_occupancy <= 5'(count_ff); state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/mppq_checker.sv
`default_nettype none
module mppq_checker
   import mppq_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire       rsp_valid_res,
   input wire       rsp_dropped,
   input wire [4:0] rsp_occupancy
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_valid_res && rsp_dropped)) else $error("valid and drop");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_occupancy))
      else $error("stalled beat changed");
   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_occupancy != 5'd0) else $error("drop when empty");
endmodule
bind multi_policy_packet_queue mppq_checker u_chk (.*);
`default_nettype wire
